>>> rtl/idll_pkg.sv
// Shared types and codes for the indexed doubly linked list core.
// No dependencies; used by indexed_doubly_linked_list_core.
`default_nettype none

package idll_pkg;

    // Field widths of the stream words
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 40;   // op + index + value, already whole bytes
    localparam int OUT_W    = 56;   // 52 bits of fields padded to 7 bytes
    localparam int OUT_PAD  = OUT_W - (3 * SLOT_W + VALUE_W + STATUS_W);

    typedef enum logic [OP_W-1:0] {
        OP_INS_BEFORE = 2'd0,
        OP_INS_AFTER  = 2'd1,
        OP_REMOVE     = 2'd2,
        OP_LOOKUP     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_INVALID = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_WR2,
        S_WALK,
        S_WALK_CAP,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

>>> rtl/idll_ram.sv
// Single-port-write, single-port-read table with registered read data.
// No dependencies; instantiated for each link/value/flag table of the list core.
`default_nettype none

module idll_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/indexed_doubly_linked_list_core.sv
// Top level: doubly linked list kept in a slot table with a free chain.
// Depends on idll_pkg (types, codes) and idll_ram (link, value and free-flag tables).
`default_nettype none

// Channel   Dir  Word bits  Contents (low bit up)
// s_axis    in   40         op[1:0], index[7:2], value[39:8]
// m_axis    out  56         slot[5:0], value_out[37:6], status[39:38],
//                           head[45:40], tail[51:46], zero[55:52]
//
// Sequencing: one word at a time through a small sequencer around four 1R1W tables.
// Insert and remove go from accept to result through S_RD1, S_RD2, S_EXEC,
// S_WR2 when a second write is needed, and S_OUT; lookup alternates S_WALK and
// S_WALK_CAP, one registered next_link read per step.
// Reset: after rst_n every slot of the link and free-flag tables is swept,
// with s_tready low. Slot values are not cleared.
// Stalls: the result sits in an output register; a new word is taken while it waits,
// and the sequencer holds in S_OUT only while that register is full and m_tready low.

module indexed_doubly_linked_list_core #(
    parameter int CAPACITY = 63
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [idll_pkg::IN_W-1:0]  s_tdata,   // op, index, value
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [idll_pkg::OUT_W-1:0] m_tdata    // slot, value_out, status, head, tail
);

    localparam int DEPTH = CAPACITY + 1;
    localparam int AW    = $clog2(DEPTH);

    typedef logic [AW-1:0] addr_t;

    // Sequencer and list registers
    idll_pkg::state_t  state_reg,   state_next;
    idll_pkg::op_t     op_reg,      op_next;
    logic [idll_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic [idll_pkg::VALUE_W-1:0] val_reg, val_next;
    addr_t             head_reg,    head_next;
    addr_t             tail_reg,    tail_next;
    addr_t             fh_reg,      fh_next;      // free chain head
    addr_t             clr_reg,     clr_next;     // sweep pointer after reset
    addr_t             p_reg,       p_next;       // prev_link of target
    addr_t             n_reg,       n_next;       // next_link of target
    logic              fb_reg,      fb_next;      // free flag of target
    addr_t             cur_reg,     cur_next;     // lookup walk pointer
    logic [idll_pkg::INDEX_W-1:0] k_reg, k_next;  // lookup steps taken
    addr_t             slot_reg,    slot_next;
    logic [idll_pkg::VALUE_W-1:0] vout_reg, vout_next;
    idll_pkg::status_t stat_reg,    stat_next;
    logic              m_valid_reg, m_valid_next;
    logic [idll_pkg::OUT_W-1:0] m_data_reg, m_data_next;

    // Table ports
    logic  nx_we, pv_we, fr_we, vl_we;
    addr_t nx_waddr, pv_waddr, fr_waddr, vl_waddr;
    addr_t nx_wdata, pv_wdata;
    logic  fr_wdata;
    logic [idll_pkg::VALUE_W-1:0] vl_wdata;
    addr_t nx_raddr;
    addr_t nx_rdata, pv_rdata;
    logic  fr_rdata;
    logic [idll_pkg::VALUE_W-1:0] vl_rdata;

    addr_t idx_a;
    logic  idx_in_range;
    logic  live;
    logic  in_accept;

    assign idx_a        = AW'(idx_reg);
    assign idx_in_range = (32'(idx_reg) <= 32'(CAPACITY));
    assign live         = (idx_reg != '0) && idx_in_range && !fb_reg;
    assign in_accept    = s_tvalid && s_tready;

    assign s_tready = (state_reg == idll_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    idll_ram #(.DEPTH(DEPTH), .DATA_W(AW)) u_next_link (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (nx_raddr),
        .rdata (nx_rdata)
    );

    idll_ram #(.DEPTH(DEPTH), .DATA_W(AW)) u_prev_link (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (idx_a),
        .rdata (pv_rdata)
    );

    idll_ram #(.DEPTH(DEPTH), .DATA_W(1)) u_slot_free (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (idx_a),
        .rdata (fr_rdata)
    );

    idll_ram #(.DEPTH(DEPTH), .DATA_W(idll_pkg::VALUE_W)) u_slot_value (
        .clk   (clk),
        .we    (vl_we),
        .waddr (vl_waddr),
        .wdata (vl_wdata),
        .raddr (idx_a),
        .rdata (vl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= idll_pkg::S_CLEAR;
            head_reg    <= '0;
            tail_reg    <= '0;
            fh_reg      <= addr_t'(1);
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fh_reg      <= fh_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
        fb_reg     <= fb_next;
        cur_reg    <= cur_next;
        k_reg      <= k_next;
        slot_reg   <= slot_next;
        vout_reg   <= vout_next;
        stat_reg   <= stat_next;
        m_data_reg <= m_data_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fh_next      = fh_reg;
        clr_next     = clr_reg;
        p_next       = p_reg;
        n_next       = n_reg;
        fb_next      = fb_reg;
        cur_next     = cur_reg;
        k_next       = k_reg;
        slot_next    = slot_reg;
        vout_next    = vout_reg;
        stat_next    = stat_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;

        nx_we = 1'b0;  nx_waddr = '0;  nx_wdata = '0;
        pv_we = 1'b0;  pv_waddr = '0;  pv_wdata = '0;
        fr_we = 1'b0;  fr_waddr = '0;  fr_wdata = 1'b0;
        vl_we = 1'b0;  vl_waddr = '0;  vl_wdata = '0;
        nx_raddr = idx_a;

        case (state_reg)
            // Rebuild the free chain 1 -> 2 -> ... -> CAPACITY -> 0
            idll_pkg::S_CLEAR:
            begin
                nx_we    = 1'b1;
                nx_waddr = clr_reg;
                nx_wdata = (clr_reg != '0 && clr_reg != addr_t'(CAPACITY)) ?
                           addr_t'(clr_reg + 1'b1) : '0;
                pv_we    = 1'b1;
                pv_waddr = clr_reg;
                pv_wdata = '0;
                fr_we    = 1'b1;
                fr_waddr = clr_reg;
                fr_wdata = (clr_reg != '0);
                if (clr_reg == addr_t'(CAPACITY))
                begin
                    state_next = idll_pkg::S_IDLE;
                end
                else
                begin
                    clr_next = addr_t'(clr_reg + 1'b1);
                end
            end

            idll_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next  = idll_pkg::op_t'(s_tdata[1:0]);
                    idx_next = s_tdata[7:2];
                    val_next = s_tdata[39:8];
                    cur_next = head_reg;
                    k_next   = '0;
                    if (idll_pkg::op_t'(s_tdata[1:0]) == idll_pkg::OP_LOOKUP)
                    begin
                        state_next = idll_pkg::S_WALK;
                    end
                    else
                    begin
                        state_next = idll_pkg::S_RD1;
                    end
                end
            end

            // Target slot's links and flag come back next cycle
            idll_pkg::S_RD1:
            begin
                nx_raddr   = idx_a;
                state_next = idll_pkg::S_RD2;
            end

            // Fetch the link after the free head
            idll_pkg::S_RD2:
            begin
                nx_raddr   = fh_reg;
                p_next     = pv_rdata;
                n_next     = nx_rdata;
                fb_next    = fr_rdata;
                state_next = idll_pkg::S_EXEC;
            end

            // Decide status, first write cycle
            idll_pkg::S_EXEC:
            begin
                slot_next  = '0;
                vout_next  = '0;
                stat_next  = idll_pkg::STAT_OK;
                state_next = idll_pkg::S_OUT;
                if (op_reg == idll_pkg::OP_INS_BEFORE || op_reg == idll_pkg::OP_INS_AFTER)
                begin
                    if (head_reg != '0 && !live)
                    begin
                        stat_next = idll_pkg::STAT_INVALID;
                    end
                    else if (fh_reg == '0)
                    begin
                        stat_next = idll_pkg::STAT_FULL;
                    end
                    else
                    begin
                        slot_next = fh_reg;
                        fh_next   = nx_rdata;
                        fr_we     = 1'b1;
                        fr_waddr  = fh_reg;
                        fr_wdata  = 1'b0;
                        vl_we     = 1'b1;
                        vl_waddr  = fh_reg;
                        vl_wdata  = val_reg;
                        nx_we     = 1'b1;
                        nx_waddr  = fh_reg;
                        pv_we     = 1'b1;
                        pv_waddr  = fh_reg;
                        if (head_reg == '0)
                        begin
                            // empty list: new slot is the whole list
                            nx_wdata  = '0;
                            pv_wdata  = '0;
                            head_next = fh_reg;
                            tail_next = fh_reg;
                        end
                        else if (op_reg == idll_pkg::OP_INS_BEFORE)
                        begin
                            nx_wdata   = idx_a;
                            pv_wdata   = p_reg;
                            state_next = idll_pkg::S_WR2;
                        end
                        else
                        begin
                            nx_wdata   = n_reg;
                            pv_wdata   = idx_a;
                            state_next = idll_pkg::S_WR2;
                        end
                    end
                end
                else
                begin
                    if (!live)
                    begin
                        stat_next = idll_pkg::STAT_INVALID;
                    end
                    else
                    begin
                        // unlink from neighbors
                        vout_next = vl_rdata;
                        if (p_reg != '0)
                        begin
                            nx_we    = 1'b1;
                            nx_waddr = p_reg;
                            nx_wdata = n_reg;
                        end
                        else
                        begin
                            head_next = n_reg;
                        end
                        if (n_reg != '0)
                        begin
                            pv_we    = 1'b1;
                            pv_waddr = n_reg;
                            pv_wdata = p_reg;
                        end
                        else
                        begin
                            tail_next = p_reg;
                        end
                        state_next = idll_pkg::S_WR2;
                    end
                end
            end

            // Second write cycle: link neighbors to the new slot, or free the removed one
            idll_pkg::S_WR2:
            begin
                state_next = idll_pkg::S_OUT;
                case (op_reg)
                    idll_pkg::OP_INS_BEFORE:
                    begin
                        pv_we    = 1'b1;
                        pv_waddr = idx_a;
                        pv_wdata = slot_reg;
                        if (p_reg != '0)
                        begin
                            nx_we    = 1'b1;
                            nx_waddr = p_reg;
                            nx_wdata = slot_reg;
                        end
                        else
                        begin
                            head_next = slot_reg;
                        end
                    end
                    idll_pkg::OP_INS_AFTER:
                    begin
                        nx_we    = 1'b1;
                        nx_waddr = idx_a;
                        nx_wdata = slot_reg;
                        if (n_reg != '0)
                        begin
                            pv_we    = 1'b1;
                            pv_waddr = n_reg;
                            pv_wdata = slot_reg;
                        end
                        else
                        begin
                            tail_next = slot_reg;
                        end
                    end
                    idll_pkg::OP_REMOVE:
                    begin
                        nx_we    = 1'b1;
                        nx_waddr = idx_a;
                        nx_wdata = fh_reg;
                        pv_we    = 1'b1;
                        pv_waddr = idx_a;
                        pv_wdata = '0;
                        fr_we    = 1'b1;
                        fr_waddr = idx_a;
                        fr_wdata = 1'b1;
                        fh_next  = idx_a;
                    end
                    default:
                    begin
                        state_next = idll_pkg::S_OUT;
                    end
                endcase
            end

            // Lookup: one next_link read per step, stop at position or null
            idll_pkg::S_WALK:
            begin
                nx_raddr = cur_reg;
                if (k_reg == idx_reg || cur_reg == '0)
                begin
                    slot_next  = cur_reg;
                    vout_next  = '0;
                    stat_next  = idll_pkg::STAT_OK;
                    state_next = idll_pkg::S_OUT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = idll_pkg::S_WALK_CAP;
                end
            end

            idll_pkg::S_WALK_CAP:
            begin
                cur_next   = nx_rdata;
                state_next = idll_pkg::S_WALK;
            end

            idll_pkg::S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{idll_pkg::OUT_PAD{1'b0}},
                                    idll_pkg::SLOT_W'(tail_reg),
                                    idll_pkg::SLOT_W'(head_reg),
                                    stat_reg,
                                    vout_reg,
                                    idll_pkg::SLOT_W'(slot_reg)};
                    state_next   = idll_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = idll_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
